// File: rtl/windowed_frame_rate_meter_unit_defines.svh
// Assertion macros shared by the frame rate meter RTL.
`ifndef WINDOWED_FRAME_RATE_METER_UNIT_DEFINES_SVH
`define WINDOWED_FRAME_RATE_METER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WFRM_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("frame rate meter assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define WFRM_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("frame rate meter assertion failed");

`endif

// File: rtl/wfrm_pkg.sv
// Package with the widths and constants of the frame rate meter.
package wfrm_pkg;

  localparam int TIME_W = 24;
  localparam int CFG_W = 16;
  localparam int FPS_W = 16;
  localparam int HELD_W = 5;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 24;

  localparam longint unsigned MICROS_PER_SECOND = 64'd1000000;
  localparam logic [CFG_W-1:0] MIN_TIME_FLOOR = 16'd16;
  localparam logic [CFG_W-1:0] MIN_TIME_RESET = 16'd100;

  localparam int WINDOW_DEPTH_DEFAULT = 16;
  localparam int RATE_FRAC_BITS_DEFAULT = 10;

endpackage

// File: rtl/windowed_frame_rate_meter_unit.sv
// Windowed frame rate meter: moving average of the reciprocal frame time.
//
// The s_axis channel takes one beat per frame, carrying the frame time in
// microseconds. The time is raised to the configured minimum, turned into a
// fixed-point rate 1e6/time and pushed into a ring of the last WINDOW_DEPTH
// samples. For each beat in, one beat leaves on m_axis with the window mean
// rounded half up to an integer rate, together with the number of samples held.
// The cfg channel writes the minimum frame time; it is always ready and should
// only be written while the block is idle.
// One bit-serial restoring divider does both divisions, one quotient bit per
// cycle. A new beat is only accepted once the result of the last one has been
// loaded into the m_axis register, and s_axis_tready rises in the same cycle
// as m_axis_tvalid.
// A new beat is taken while an earlier result still waits on m_axis; the block
// only holds its next result when the receiver has not taken the last one.
// Reset empties the window and sets the minimum frame time to 100 us.
`include "windowed_frame_rate_meter_unit_defines.svh"

module windowed_frame_rate_meter_unit
  import wfrm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT,
  parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [23:0] frame_time_us
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] fps_rounded, [20:16] samples_held
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int SAMPLE_W = 16 + RATE_FRAC_BITS;
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int DIV1_W = 20 + RATE_FRAC_BITS;
  localparam int NUM_W = SUM_W + 2;
  localparam int DIV_W = (DIV1_W > NUM_W) ? DIV1_W : NUM_W;
  localparam int ITER_W = $clog2(DIV_W + 1);
  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [DIV_W-1:0] RATE_NUM = DIV_W'(MICROS_PER_SECOND << RATE_FRAC_BITS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(WINDOW_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_NUM  = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]          state;
  logic [CFG_W-1:0]    min_time;
  logic [SLOT_W-1:0]   write_slot;
  logic [FILL_W-1:0]   fill_count;
  logic [SUM_W-1:0]    window_sum;
  logic [SAMPLE_W-1:0] sample_ring [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] sample;
  logic [DIV_W-1:0]    quo;
  logic [TIME_W-1:0]   rem;
  logic [TIME_W-1:0]   dsr;
  logic [ITER_W-1:0]   iter;
  logic [FPS_W-1:0]    fps_out;
  logic [HELD_W-1:0]   held_out;

  logic                in_beat;
  logic [TIME_W-1:0]   frame_time;
  logic [TIME_W:0]     rem_shift;
  logic [TIME_W+1:0]   trial;
  logic                ring_full;
  logic                out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign ring_full = (fill_count == FULL_COUNT);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {{(OUT_DATA_W - FPS_W - HELD_W){1'b0}}, held_out, fps_out};

  always_comb begin
    frame_time = s_axis_tdata[TIME_W-1:0];
    if (frame_time < TIME_W'(min_time)) begin
      frame_time = TIME_W'(min_time);
    end
    rem_shift = {rem, quo[DIV_W-1]};
    trial = {1'b0, rem_shift} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_time <= MIN_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_time <= (cfg_data < MIN_TIME_FLOOR) ? MIN_TIME_FLOOR : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      old_sample <= sample_ring[write_slot];
    end
    if (state == S_ADD) begin
      sample_ring[write_slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      window_sum <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            quo <= RATE_NUM;
            rem <= '0;
            dsr <= frame_time;
            iter <= ITER_W'(DIV_W);
            state <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          if (iter != '0) begin
            if (!trial[TIME_W+1]) begin
              rem <= trial[TIME_W-1:0];
            end else begin
              rem <= rem_shift[TIME_W-1:0];
            end
            quo <= {quo[DIV_W-2:0], !trial[TIME_W+1]};
            iter <= iter - 1'b1;
          end else if (state == S_DIV1) begin
            sample <= quo[SAMPLE_W-1:0];
            state <= S_SUB;
          end else begin
            state <= S_OUT;
          end
        end
        S_SUB: begin
          if (ring_full) begin
            window_sum <= window_sum - SUM_W'(old_sample);
          end
          state <= S_ADD;
        end
        S_ADD: begin
          window_sum <= window_sum + SUM_W'(sample);
          write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
          if (!ring_full) begin
            fill_count <= fill_count + 1'b1;
          end
          state <= S_NUM;
        end
        S_NUM: begin
          quo <= DIV_W'({window_sum, 1'b0}) + (DIV_W'(fill_count) << RATE_FRAC_BITS);
          rem <= '0;
          dsr <= TIME_W'(fill_count);
          iter <= ITER_W'(DIV_W);
          state <= S_DIV2;
        end
        S_OUT: begin
          if (out_free) begin
            fps_out <= FPS_W'(quo >> (RATE_FRAC_BITS + 1));
            held_out <= HELD_W'(fill_count);
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WFRM_ASSERT_NEXT(a_accept_starts_divide, clk, rst, in_beat, state == S_DIV1)
  `WFRM_ASSERT_NEXT(a_pending_result_held, clk, rst,
                    state == S_OUT && m_axis_tvalid && !m_axis_tready, state == S_OUT)
  `WFRM_ASSERT_SAME(a_remainder_below_divisor, clk, rst,
                    state == S_DIV1 || state == S_DIV2, rem < dsr)
  `WFRM_ASSERT_SAME(a_result_has_samples, clk, rst, m_axis_tvalid,
                    fill_count != '0 && fill_count <= FULL_COUNT)

endmodule
